// File: hw/rtl/pgalloc_pkg.sv
// ----------------------------------------------------------------------------
// Page allocator package
// Shared types, codes and default sizes for the page allocator.
// ----------------------------------------------------------------------------
package pgalloc_pkg;

    localparam int PAGE_W         = 15;
    localparam int REF_W          = 8;
    localparam int PAGES_DEF      = 32768;
    localparam int COUNT_BITS_DEF = 8;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_INC   = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SRC_STACK = 2'd0,
        SRC_FRESH = 2'd1,
        SRC_NONE  = 2'd2
    } t_src;

    typedef struct packed {
        t_action            action;
        logic [PAGE_W-1:0]  page;
    } t_in_item;

    typedef struct packed {
        logic [PAGE_W-1:0]  page_out;
        logic [REF_W-1:0]   ref_value;
        logic               returned_to_pool;
        t_status            status;
    } t_out_item;

    typedef struct packed {
        t_action            action;
        logic [PAGE_W-1:0]  page;
        t_src               src;
        logic               range_err;
    } t_req;

    typedef struct packed {
        logic cnt_we;
        logic push;
        logic pop;
        logic fresh_dec;
    } t_wb;

endpackage

// File: hw/rtl/pgalloc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pgalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pgalloc_exec.sv
// ----------------------------------------------------------------------------
// Page allocator execute stage
// Turns a latched request and the memory read data into the result beat and
// the write-back controls for the count and stack memories.
// ----------------------------------------------------------------------------
module pgalloc_exec import pgalloc_pkg::*; #(
    parameter int PAGES      = PAGES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  t_req                         i_req,
    input  logic [COUNT_BITS-1:0]        i_cnt_rdata,
    input  logic [PAGE_W-1:0]            i_stack_rdata,
    input  logic                         i_stack_full,
    input  logic [$clog2(PAGES)-1:0]     i_fresh_page,
    output t_out_item                    o_result,
    output t_wb                          o_wb,
    output logic [$clog2(PAGES)-1:0]     o_cnt_addr,
    output logic [COUNT_BITS-1:0]        o_cnt_wdata
);

    localparam int ADDR_W = $clog2(PAGES);

    logic [ADDR_W-1:0]       w_got;
    logic [COUNT_BITS-1:0]   w_cnt_next;
    logic [COUNT_BITS+REF_W-1:0] w_ref_ext;

    assign w_ref_ext = {{REF_W{1'b0}}, w_cnt_next};

    always_comb begin
        w_got       = (i_req.src == SRC_STACK) ? ADDR_W'(i_stack_rdata) : i_fresh_page;
        w_cnt_next  = i_cnt_rdata;
        o_wb        = '0;
        o_cnt_addr  = ADDR_W'(i_req.page);
        o_cnt_wdata = '0;
        o_result.page_out         = i_req.page;
        o_result.returned_to_pool = 1'b0;
        o_result.status           = ST_OK;

        if (i_req.action == ACT_ALLOC) begin
            o_result.page_out = PAGE_W'(w_got);
            o_cnt_addr        = w_got;
            o_cnt_wdata       = COUNT_BITS'(1);
            w_cnt_next        = COUNT_BITS'(1);
            unique case (i_req.src)
                SRC_STACK: begin
                    o_wb.cnt_we = 1'b1;
                    o_wb.pop    = 1'b1;
                end
                SRC_FRESH: begin
                    o_wb.cnt_we    = 1'b1;
                    o_wb.fresh_dec = 1'b1;
                end
                default: begin
                    o_result.page_out = '0;
                    o_result.status   = ST_EMPTY;
                    w_cnt_next        = '0;
                end
            endcase
        end else if (i_req.range_err) begin
            o_result.status = ST_RANGE;
            w_cnt_next      = '0;
        end else begin
            case (i_req.action)
                ACT_FREE: begin
                    if (i_cnt_rdata > COUNT_BITS'(1)) begin
                        w_cnt_next  = i_cnt_rdata - COUNT_BITS'(1);
                        o_cnt_wdata = w_cnt_next;
                        o_wb.cnt_we = 1'b1;
                    end else if (i_stack_full) begin
                        o_result.status = ST_SAT;
                    end else begin
                        w_cnt_next  = '0;
                        o_wb.cnt_we = 1'b1;
                        o_wb.push   = 1'b1;
                        o_result.returned_to_pool = 1'b1;
                    end
                end
                ACT_INC: begin
                    if (&i_cnt_rdata) begin
                        o_result.status = ST_SAT;
                    end else begin
                        w_cnt_next  = i_cnt_rdata + COUNT_BITS'(1);
                        o_cnt_wdata = w_cnt_next;
                        o_wb.cnt_we = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        o_result.ref_value = w_ref_ext[REF_W-1:0];
    end

endmodule

// File: hw/rtl/page_allocator_with_refcount.sv
// ----------------------------------------------------------------------------
// Page allocator with reference counts
// Free-stack page allocator with per-page reference counts held in memory.
// ----------------------------------------------------------------------------
// Each request reads the count memory and the free stack memory, then modifies
// the count and writes it back; the next request is accepted once the
// write-back is done, so a new request is not taken while one is in progress.
// Results wait in an output register, and a new request is taken as long as
// that register is empty or is being emptied in the same cycle. After reset a
// clearing pass zeroes every entry of the count memory, and no request is
// accepted until it ends; configuration writes are taken at any time.
module page_allocator_with_refcount import pgalloc_pkg::*; #(
    parameter int PAGES      = PAGES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [PAGE_W-1:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(PAGES);
    localparam int NF_W   = $clog2(PAGES + 1);

    typedef enum logic [2:0] {
        S_CLR  = 3'b001,
        S_IDLE = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [PAGE_W-1:0]   r_ffp, n_ffp;
    logic [NF_W-1:0]     r_depth, n_depth;
    logic [NF_W-1:0]     r_next_fresh, n_next_fresh;
    t_req                r_req, n_req;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_item, n_out_item;

    logic                w_in_acc;
    logic                w_exec;
    t_out_item           w_result;
    t_wb                 w_wb;
    logic [ADDR_W-1:0]   w_exec_addr;
    logic [COUNT_BITS-1:0] w_exec_wdata;
    logic [COUNT_BITS-1:0] w_cnt_rdata;
    logic [PAGE_W-1:0]   w_stack_rdata;
    logic [NF_W-1:0]     w_depth_dec;
    logic [NF_W-1:0]     w_fresh_dec;
    logic                w_stack_full;
    logic                w_cnt_we;
    logic [ADDR_W-1:0]   w_cnt_waddr;
    logic [COUNT_BITS-1:0] w_cnt_wdata;

    assign o_in_stall   = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_exec       = (r_state == S_EXEC);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_out_item   = r_out_item;
    assign w_depth_dec  = r_depth - NF_W'(1);
    assign w_fresh_dec  = r_next_fresh - NF_W'(1);
    assign w_stack_full = (r_depth == NF_W'(PAGES));

    assign w_cnt_we    = (r_state == S_CLR) || (w_exec && w_wb.cnt_we);
    assign w_cnt_waddr = (r_state == S_CLR) ? r_clr_addr : w_exec_addr;
    assign w_cnt_wdata = (r_state == S_CLR) ? '0 : w_exec_wdata;

    pgalloc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (PAGES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_re    (w_in_acc),
        .i_raddr (ADDR_W'(i_in_item.page)),
        .o_rdata (w_cnt_rdata)
    );

    pgalloc_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (PAGES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_exec && w_wb.push),
        .i_waddr (r_depth[ADDR_W-1:0]),
        .i_wdata (r_req.page),
        .i_re    (w_in_acc),
        .i_raddr (w_depth_dec[ADDR_W-1:0]),
        .o_rdata (w_stack_rdata)
    );

    pgalloc_exec #(
        .PAGES      (PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_exec (
        .i_req         (r_req),
        .i_cnt_rdata   (w_cnt_rdata),
        .i_stack_rdata (w_stack_rdata),
        .i_stack_full  (w_stack_full),
        .i_fresh_page  (w_fresh_dec[ADDR_W-1:0]),
        .o_result      (w_result),
        .o_wb          (w_wb),
        .o_cnt_addr    (w_exec_addr),
        .o_cnt_wdata   (w_exec_wdata)
    );

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_ffp        = r_ffp;
        n_depth      = r_depth;
        n_next_fresh = r_next_fresh;
        n_req        = r_req;
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;

        if (i_cfg_valid) begin
            n_ffp = i_cfg_data;
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_req.action    = i_in_item.action;
                    n_req.page      = i_in_item.page;
                    n_req.range_err = (i_in_item.page < r_ffp) ||
                                      (32'(i_in_item.page) >= 32'(PAGES));
                    if (r_depth != '0) begin
                        n_req.src = SRC_STACK;
                    end else if (32'(r_next_fresh) > 32'(r_ffp)) begin
                        n_req.src = SRC_FRESH;
                    end else begin
                        n_req.src = SRC_NONE;
                    end
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out_valid = 1'b1;
                n_out_item  = w_result;
                if (w_wb.pop) begin
                    n_depth = w_depth_dec;
                end
                if (w_wb.push) begin
                    n_depth = r_depth + NF_W'(1);
                end
                if (w_wb.fresh_dec) begin
                    n_next_fresh = w_fresh_dec;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_addr   <= '0;
            r_ffp        <= '0;
            r_depth      <= '0;
            r_next_fresh <= NF_W'(PAGES);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_ffp        <= n_ffp;
            r_depth      <= n_depth;
            r_next_fresh <= n_next_fresh;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_out_item <= n_out_item;
    end

    a_exec_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !r_out_valid)
        else $error("result register busy when a request completes");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execution");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= 32'(PAGES))
        else $error("free stack depth beyond capacity");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_next_fresh) <= 32'(PAGES))
        else $error("fresh page pointer beyond capacity");

endmodule
